// ===== rtl/ptc_pkg.sv =====
// Shared types, constants and helpers for the pressure/temperature compensation core.
`default_nettype none
package ptc_pkg;

    localparam int RawW        = 20;
    localparam int FrontStages = 9;
    localparam int DivStages   = 32;
    // divider side channel: temp_centi[31:0], small flag[32], zero-divisor flag[33]
    localparam int SideW       = 34;

    typedef enum logic [1:0] {
        REG_TEMP_CAL  = 2'd0,
        REG_PRESS_LOW = 2'd1,
        REG_PRESS_HI  = 2'd2,
        REG_PRESS_P9  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } t_cal;

    // Arithmetic right shift on a 32-bit pattern.
    function automatic logic [31:0] sar(input logic [31:0] x, input int s);
        sar = 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ptc_divider.sv =====
// Pipelined restoring 32-bit unsigned divider, one quotient bit per stage.
`default_nettype none
module ptc_divider
    import ptc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_num,
    input  wire logic [31:0]       i_den,
    input  wire logic [SideW-1:0]  i_side,
    output logic                   o_valid,
    output logic [31:0]            o_quot,
    output logic [SideW-1:0]       o_side
);
    // side carries temp and the divide flags through the stages
    logic [DivStages:1]  r_v;
    logic [31:0]         r_quot [1:DivStages];
    logic [SideW-1:0]    r_side [1:DivStages];
    logic [31:0]         r_rem  [1:DivStages-1];
    logic [31:0]         r_num  [1:DivStages-1];
    logic [31:0]         r_den  [1:DivStages-1];

    for (genvar k = 0; k < DivStages; k++) begin : g_stage
        logic             v_in;
        logic [31:0]      rem_in, quot_in, num_in, den_in;
        logic [SideW-1:0] side_in;
        logic [32:0]      trial;
        logic [32:0]      diff;

        if (k == 0) begin : g_src
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign quot_in = '0;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_src
            assign v_in    = r_v[k];
            assign rem_in  = r_rem[k];
            assign quot_in = r_quot[k];
            assign num_in  = r_num[k];
            assign den_in  = r_den[k];
            assign side_in = r_side[k];
        end

        assign trial = {rem_in, num_in[31]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= side_in;
                r_quot[k+1] <= {quot_in[30:0], ~diff[32]};
            end
        end

        // the last stage only needs the final quotient bit
        if (k < DivStages - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k+1] <= {num_in[30:0], 1'b0};
                    r_den[k+1] <= den_in;
                    if (!diff[32]) begin
                        r_rem[k+1] <= diff[31:0];
                    end else begin
                        r_rem[k+1] <= trial[31:0];
                    end
                end
            end
        end
    end

    assign o_valid = r_v[DivStages];
    assign o_quot  = r_quot[DivStages];
    assign o_side  = r_side[DivStages];
endmodule
`default_nettype wire

// ===== rtl/ptc_front.sv =====
// Temperature path and pressure divisor/numerator, pipelined across register stages.
`default_nettype none
module ptc_front
    import ptc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [RawW-1:0]   i_raw_temp,
    input  wire logic [RawW-1:0]   i_raw_press,
    input  wire t_cal              i_cal,
    output logic                   o_valid,
    output logic [31:0]            o_temp,
    output logic [31:0]            o_num,
    output logic [31:0]            o_den,
    output logic                   o_num_small
);
    logic [FrontStages-1:0] r_v;

    // stage 1
    logic [31:0] r1_x, r1_d, r1_adcp;
    // stage 2
    logic [31:0] r2_a, r2_dd, r2_adcp;
    // stage 3
    logic [31:0] r3_a, r3_m, r3_adcp;
    // stage 4: fine
    logic [31:0] r4_fine, r4_adcp;
    // stage 5
    logic [31:0] r5_temp, r5_a, r5_sq, r5_adcp;
    // stage 6
    logic [31:0] r6_temp, r6_b6, r6_a5, r6_m3, r6_m2, r6_adcp;
    // stage 7
    logic [31:0] r7_temp, r7_b, r7_s, r7_adcp;
    // stage 8
    logic [31:0] r8_temp, r8_den, r8_nb;
    // stage 9
    logic [31:0] r9_temp, r9_den, r9_num;

    logic [31:0] adc_t, adc_p;
    assign adc_t = {12'd0, i_raw_temp};
    assign adc_p = {12'd0, i_raw_press};

    logic [31:0] n5_a, n7_a, n8_nb;
    assign n5_a  = sar(r4_fine, 1) - 32'd64000;
    assign n7_a  = sar(sar(r6_m3, 3) + sar(r6_m2, 1), 18);
    assign n8_nb = (32'd1048576 - r7_adcp) - sar(r7_b, 12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FrontStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x    <= (adc_t >> 3) - (i_cal.t1 << 1);
            r1_d    <= (adc_t >> 4) - i_cal.t1;
            r1_adcp <= adc_p;

            r2_a    <= sar(r1_x * i_cal.t2, 11);
            r2_dd   <= sar(r1_d * r1_d, 12);
            r2_adcp <= r1_adcp;

            r3_a    <= r2_a;
            r3_m    <= r2_dd * i_cal.t3;
            r3_adcp <= r2_adcp;

            r4_fine <= r3_a + sar(r3_m, 14);
            r4_adcp <= r3_adcp;

            r5_temp <= r4_fine * 32'd5;
            r5_a    <= n5_a;
            r5_sq   <= sar(n5_a, 2) * sar(n5_a, 2);
            r5_adcp <= r4_adcp;

            r6_temp <= sar(r5_temp + 32'd128, 8);
            r6_b6   <= sar(r5_sq, 11) * i_cal.p6;
            r6_a5   <= r5_a * i_cal.p5;
            r6_m3   <= i_cal.p3 * sar(r5_sq, 13);
            r6_m2   <= i_cal.p2 * r5_a;
            r6_adcp <= r5_adcp;

            r7_temp <= r6_temp;
            r7_b    <= sar(r6_b6 + (r6_a5 << 1), 2) + (i_cal.p4 << 16);
            r7_s    <= 32'd32768 + n7_a;
            r7_adcp <= r6_adcp;

            r8_temp <= r7_temp;
            r8_den  <= sar(r7_s * i_cal.p1, 15);
            r8_nb   <= n8_nb;

            r9_temp <= r8_temp;
            r9_den  <= r8_den;
            r9_num  <= r8_nb * 32'd3125;
        end
    end

    assign o_valid     = r_v[FrontStages-1];
    assign o_temp      = r9_temp;
    assign o_den       = r9_den;
    assign o_num_small = ~r9_num[31];
    assign o_num       = r9_num[31] ? r9_num : (r9_num << 1);
endmodule
`default_nettype wire

// ===== rtl/ptc_back.sv =====
// Post-division pressure correction with P7..P9, three register stages.
`default_nettype none
module ptc_back
    import ptc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [31:0]  i_quot,
    input  wire logic         i_small,
    input  wire logic         i_zero,
    input  wire logic [31:0]  i_temp,
    input  wire t_cal         i_cal,
    output logic              o_valid,
    output logic [31:0]       o_temp,
    output logic [31:0]       o_press
);
    logic [2:0]  r_v;
    logic [31:0] r1_p, r1_t, r2_p, r2_t, r2_sq, r2_b, r3_p, r3_t;
    logic        r1_z, r2_z;
    logic [31:0] p3sh, sq;
    logic [31:0] r3_a;

    assign p3sh = r1_p >> 3;
    assign sq   = (p3sh * p3sh) >> 13;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p  <= i_small ? i_quot : (i_quot << 1);
            r1_t  <= i_temp;
            r1_z  <= i_zero;
            r2_p  <= r1_p;
            r2_t  <= r1_t;
            r2_z  <= r1_z;
            r2_sq <= sq;
            r2_b  <= sar((r1_p >> 2) * i_cal.p8, 13);
            r3_a  <= sar(i_cal.p9 * r2_sq, 12);
            r3_p  <= r2_z ? 32'd0 : r2_p;
            r3_t  <= r2_t;
        end
    end

    logic [31:0] r3_b;
    logic        r3_z;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_b <= r2_b;
            r3_z <= r2_z;
        end
    end

    assign o_valid = r_v[2];
    assign o_temp  = r3_t;
    assign o_press = r3_z ? 32'd0 : r3_p + sar(r3_a + r3_b + i_cal.p7, 4);
endmodule
`default_nettype wire

// ===== rtl/pressure_temperature_compensation_core.sv =====
// Top level: configuration registers, pipeline, output register.
`default_nettype none
// Fully pipelined compensation of 20-bit raw temperature/pressure pairs. One beat
// is accepted every cycle while the output is not stalled; the pipe holds 9 front
// stages, 32 divider stages (one quotient bit each, the dominant depth), 3
// correction stages and the output register. The whole pipe advances when the
// output register is empty or being taken, so a stall freezes every stage in
// place. Calibration is written through the cfg channel (always ready) and must
// be stable while beats are in flight.
module pressure_temperature_compensation_core
    import ptc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // raw_temp[19:0], raw_press[39:20], zero pad
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // temp_centi[31:0], press_pa[63:32]
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_low, r_press_hi;
    logic [15:0] r_p9;
    t_cal        cal;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal  <= '0;
            r_press_low <= '0;
            r_press_hi  <= '0;
            r_p9        <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_TEMP_CAL:  r_temp_cal  <= i_cfg_data[47:0];
                REG_PRESS_LOW: r_press_low <= i_cfg_data;
                REG_PRESS_HI:  r_press_hi  <= i_cfg_data;
                REG_PRESS_P9:  r_p9        <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1 = {16'd0, r_temp_cal[15:0]};
        cal.t2 = sx16(r_temp_cal[31:16]);
        cal.t3 = sx16(r_temp_cal[47:32]);
        cal.p1 = {16'd0, r_press_low[15:0]};
        cal.p2 = sx16(r_press_low[31:16]);
        cal.p3 = sx16(r_press_low[47:32]);
        cal.p4 = sx16(r_press_low[63:48]);
        cal.p5 = sx16(r_press_hi[15:0]);
        cal.p6 = sx16(r_press_hi[31:16]);
        cal.p7 = sx16(r_press_hi[47:32]);
        cal.p8 = sx16(r_press_hi[63:48]);
        cal.p9 = sx16(r_p9);
    end

    logic en;
    logic r_out_v;
    logic [63:0] r_out_d;
    assign en = !r_out_v || m_axis_tready;
    assign s_axis_tready = en;

    logic        f_v, f_small;
    logic [31:0] f_temp, f_num, f_den;

    ptc_front u_front (
        .i_clk, .i_rst_n, .i_en(en),
        .i_valid(s_axis_tvalid),
        .i_raw_temp(s_axis_tdata[19:0]),
        .i_raw_press(s_axis_tdata[39:20]),
        .i_cal(cal),
        .o_valid(f_v), .o_temp(f_temp), .o_num(f_num), .o_den(f_den),
        .o_num_small(f_small)
    );

    // side channel: temp, small flag, zero-divisor flag
    logic [SideW-1:0] side_in, side_out;
    logic        d_v;
    logic [31:0] d_q;
    assign side_in = {(f_den == 32'd0), f_small, f_temp};

    ptc_divider u_div (
        .i_clk, .i_rst_n, .i_en(en),
        .i_valid(f_v), .i_num(f_num), .i_den(f_den), .i_side(side_in),
        .o_valid(d_v), .o_quot(d_q), .o_side(side_out)
    );

    logic        b_v;
    logic [31:0] b_t, b_p;

    ptc_back u_back (
        .i_clk, .i_rst_n, .i_en(en),
        .i_valid(d_v), .i_quot(d_q),
        .i_small(side_out[32]), .i_zero(side_out[33]), .i_temp(side_out[31:0]),
        .i_cal(cal),
        .o_valid(b_v), .o_temp(b_t), .o_press(b_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_d <= {b_p, b_t};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !m_axis_tready |=> r_out_v && $stable(r_out_d))
        else $error("output beat lost under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipe frozen");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
endmodule
`default_nettype wire
